// File: sv/ssl_pkg.sv
`default_nettype none

package ssl_pkg;

    localparam int unsigned NUM_METH = 14;
    localparam logic [4:0]  POS_MAX  = 5'd31;

    // parse_status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REQ_ERR  = 2'd1;
    localparam logic [1:0] ST_RESP_ERR = 2'd2;
    localparam logic [1:0] ST_UNSUP    = 2'd3;

    // method_kind codes
    localparam logic [3:0] KIND_NONE  = 4'd0;
    localparam logic [3:0] KIND_OTHER = 4'd15;

    // token_index codes
    localparam logic [1:0] TOK_METHOD = 2'd0;
    localparam logic [1:0] TOK_URI    = 2'd1;
    localparam logic [1:0] TOK_REST  = 2'd2;

    // check flag bits
    localparam int unsigned F_RESP = 0;
    localparam int unsigned F_V20  = 1;
    localparam int unsigned F_METH = 2;
    localparam int unsigned F_URI  = 3;
    localparam int unsigned F_RVER = 4;

    localparam logic [4:0] RESP_MIN_LEN = 5'd10;
    localparam logic [4:0] REQ_MIN_LEN  = 5'd19;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // method names, right aligned, first character in the highest used byte
    localparam logic [71:0] METH_NAME [NUM_METH] = '{
        72'("INVITE"), 72'("ACK"), 72'("BYE"), 72'("CANCEL"), 72'("REGISTER"),
        72'("OPTIONS"), 72'("PRACK"), 72'("SUBSCRIBE"), 72'("NOTIFY"),
        72'("PUBLISH"), 72'("INFO"), 72'("REFER"), 72'("MESSAGE"), 72'("UPDATE")
    };
    localparam logic [3:0] METH_LEN [NUM_METH] = '{
        4'd6, 4'd3, 4'd3, 4'd6, 4'd8, 4'd7, 4'd5, 4'd9, 4'd6, 4'd7, 4'd4, 4'd5, 4'd7, 4'd6
    };

    // method matcher inputs for one beat
    typedef struct packed {
        logic       active;   // byte belongs to the method token
        logic [7:0] data;
        logic [4:0] tok_pos;
    } t_meth_in;

    // "SIP/2.0"
    function automatic logic [7:0] ver_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h53;  // S
            3'd1:    c = 8'h49;  // I
            3'd2:    c = 8'h50;  // P
            3'd3:    c = 8'h2F;  // /
            3'd4:    c = 8'h32;  // 2
            3'd5:    c = 8'h2E;  // .
            3'd6:    c = 8'h30;  // 0
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "sip:"
    function automatic logic [7:0] uri_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h73;  // s
            2'd1:    c = 8'h69;  // i
            2'd2:    c = 8'h70;  // p
            default: c = 8'h3A;  // :
        endcase
        return c;
    endfunction

    function automatic logic [4:0] sat_inc(input logic [4:0] v);
        return (v == POS_MAX) ? POS_MAX : v + 5'd1;
    endfunction

endpackage

`default_nettype wire

// File: sv/ssl_method_match.sv
`default_nettype none

module ssl_method_match (
    input  wire  ssl_pkg::t_meth_in              i_beat,
    input  wire  logic [ssl_pkg::NUM_METH-1:0]   i_alive,
    output logic [ssl_pkg::NUM_METH-1:0]         o_alive,
    output logic [3:0]                           o_kind
);
    import ssl_pkg::*;

    logic       is_space;
    logic [3:0] sh [NUM_METH];

    assign is_space = (i_beat.data == CH_SPACE);

    always_comb begin
        o_alive = i_alive;
        for (int i = 0; i < NUM_METH; i++) begin
            sh[i] = METH_LEN[i] - 4'd1 - i_beat.tok_pos[3:0];
            if (i_beat.active) begin
                if (is_space) begin
                    if ({1'b0, METH_LEN[i]} != i_beat.tok_pos) begin
                        o_alive[i] = 1'b0;
                    end
                end else if (i_beat.tok_pos >= {1'b0, METH_LEN[i]} ||
                             i_beat.data != 8'(METH_NAME[i] >> {sh[i], 3'b000})) begin
                    o_alive[i] = 1'b0;
                end
            end
        end
    end

    // first surviving name wins
    always_comb begin
        o_kind = KIND_OTHER;
        for (int i = NUM_METH - 1; i >= 0; i--) begin
            if (o_alive[i]) begin
                o_kind = 4'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/sip_start_line_parser.sv
// The last byte's beat passes the input holding register and then the result register on its way to the master side.
// Throughput: one byte per cycle; a result that waits stalls only the last byte.
// Reset (i_rst_n low, synchronous): parse state back to its idle values,
// both holding registers emptied. Parse state also resets after every result.
`default_nettype none

module sip_start_line_parser (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_s_tvalid,
    output logic              o_s_tready,
    input  wire  logic [7:0]  i_s_tdata,   // [7:0] line_byte
    input  wire  logic        i_s_tlast,   // line_end
    output logic              o_m_tvalid,
    input  wire  logic        i_m_tready,
    output logic [23:0]       o_m_tdata    // [0] is_response, [4:1] method_kind,
                                           // [14:5] status_code,
                                           // [16:15] parse_status, [23:17] zero
);
    import ssl_pkg::*;

    // input holding register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parse state
    logic [4:0]          r_line_pos,  n_line_pos;
    logic [1:0]          r_tok_idx,   n_tok_idx;
    logic [4:0]          r_tok_pos,   n_tok_pos;
    logic [NUM_METH-1:0] r_alive,     n_alive;
    logic [4:0]          r_flags,     n_flags;
    logic [9:0]          r_code,      n_code;
    logic                r_digits_ok, n_digits_ok;
    logic                r_reason,    n_reason;

    // result register
    logic        r_out_valid;
    logic [16:0] r_out;
    logic [16:0] n_out;

    logic       advance;
    logic       is_space;
    logic       is_digit;
    logic [3:0] kind;
    t_meth_in   meth_beat;

    // The held byte moves on unless it ends a line and the result slot is
    // still occupied and not being read.
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    assign is_space = (r_in_byte == CH_SPACE);
    assign is_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);

    assign meth_beat.active  = (r_tok_idx == TOK_METHOD);
    assign meth_beat.data    = r_in_byte;
    assign meth_beat.tok_pos = r_tok_pos;

    ssl_method_match u_match (
        .i_beat  (meth_beat),
        .i_alive (r_alive),
        .o_alive (n_alive),
        .o_kind  (kind)
    );

    // per-byte state update
    always_comb begin
        n_flags     = r_flags;
        n_tok_idx   = r_tok_idx;
        n_tok_pos   = sat_inc(r_tok_pos);
        n_code      = r_code;
        n_digits_ok = r_digits_ok;
        n_reason    = r_reason;
        n_line_pos  = sat_inc(r_line_pos);

        // line prefix checks: "SIP/" marks a response, "SIP/2.0" its version
        if (r_line_pos < 5'd4 && r_in_byte != ver_char(r_line_pos[2:0])) begin
            n_flags[F_RESP] = 1'b0;
        end
        if (r_line_pos < 5'd7 && r_in_byte != ver_char(r_line_pos[2:0])) begin
            n_flags[F_V20] = 1'b0;
        end

        case (r_tok_idx)
            TOK_METHOD: begin
                if (is_space) begin
                    if (r_tok_pos == 5'd0) begin
                        n_flags[F_METH] = 1'b0;
                    end
                    n_tok_idx = TOK_URI;
                    n_tok_pos = 5'd0;
                end
            end
            TOK_URI: begin
                // second token is the URI of a request or the code of a response
                if (is_space) begin
                    if (r_tok_pos < 5'd4) begin
                        n_flags[F_URI] = 1'b0;
                    end
                    if (r_tok_pos != 5'd3) begin
                        n_digits_ok = 1'b0;
                    end
                    n_tok_idx = TOK_REST;
                    n_tok_pos = 5'd0;
                end else begin
                    if (r_tok_pos < 5'd4 && r_in_byte != uri_char(r_tok_pos[1:0])) begin
                        n_flags[F_URI] = 1'b0;
                    end
                    if (r_tok_pos < 5'd3 && is_digit) begin
                        n_code = 10'(({r_code, 3'b000}) + ({r_code, 1'b0})
                                     + 13'(r_in_byte - CH_ZERO));
                    end else begin
                        n_digits_ok = 1'b0;
                    end
                end
            end
            default: begin
                // remainder: reason phrase, or request version
                n_reason = 1'b1;
                if (r_tok_pos < 5'd7 && r_in_byte != ver_char(r_tok_pos[2:0])) begin
                    n_flags[F_RVER] = 1'b0;
                end
            end
        endcase
    end

    // verdict at the last byte, from the updated state
    always_comb begin
        logic       resp;
        logic [3:0] kd;
        logic [9:0] cd;
        logic [1:0] st;
        resp = 1'b0;
        kd   = KIND_NONE;
        cd   = 10'd0;
        st   = ST_OK;
        if (n_line_pos >= 5'd4 && n_flags[F_RESP]) begin
            resp = 1'b1;
            if (n_line_pos < RESP_MIN_LEN) begin
                st = ST_RESP_ERR;
            end else if (!n_flags[F_V20] || n_tok_idx == TOK_METHOD) begin
                st = ST_UNSUP;
            end else if (n_tok_idx == TOK_URI || !n_reason || !n_digits_ok) begin
                st = ST_RESP_ERR;
            end else begin
                cd = n_code;
            end
        end else begin
            if (n_line_pos < REQ_MIN_LEN) begin
                st = ST_REQ_ERR;
            end else if (n_tok_idx == TOK_METHOD || !n_flags[F_METH]) begin
                st = ST_REQ_ERR;
            end else if (n_tok_idx == TOK_URI || !n_flags[F_URI]) begin
                st = ST_UNSUP;
            end else if (n_tok_pos < 5'd7 || !n_flags[F_RVER]) begin
                st = ST_UNSUP;
            end else begin
                kd = kind;
            end
        end
        n_out = {st, cd, kd, resp};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // parse state: back to idle after each line's last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_line_pos  <= 5'd0;
            r_tok_idx   <= TOK_METHOD;
            r_tok_pos   <= 5'd0;
            r_alive     <= '1;
            r_flags     <= '1;
            r_code      <= 10'd0;
            r_digits_ok <= 1'b1;
            r_reason    <= 1'b0;
        end else if (advance) begin
            r_line_pos  <= n_line_pos;
            r_tok_idx   <= n_tok_idx;
            r_tok_pos   <= n_tok_pos;
            r_alive     <= n_alive;
            r_flags     <= n_flags;
            r_code      <= n_code;
            r_digits_ok <= n_digits_ok;
            r_reason    <= n_reason;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out};

endmodule

`default_nettype wire
